// ===== hw/rtl/dst_rule_evaluator_assert.svh =====
// Assertion macros for the checker file.
`ifndef DST_RULE_EVALUATOR_ASSERT_SVH
`define DST_RULE_EVALUATOR_ASSERT_SVH

// Checked on every clock edge outside reset.
`define DRE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define DRE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hw/rtl/dre_pkg.sv =====
package dre_pkg;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 8;
   localparam int ZONE_W     = 3;
   localparam int DOY_W      = 9;
   localparam int STAMP_W    = 20;
   localparam int OFFSET_W   = 6;

   localparam logic [ZONE_W-1:0] ZONE_OFF = '0;

   // floor(x / 25) for 12-bit x as (x * RECIP25) >> 16
   localparam int RECIP25 = 2622;
   // floor(v / 7) for 9-bit v as (v * RECIP7) >> 13
   localparam int RECIP7  = 1171;
   localparam int MIN_PER_DAY = 1440;

   typedef struct packed {
      logic [3:0]          s_month;
      logic                s_last;
      logic [1:0]          s_nth;
      logic [4:0]          s_hour;
      logic [3:0]          e_month;
      logic                e_last;
      logic [1:0]          e_nth;
      logic [4:0]          e_hour;
      logic [OFFSET_W-1:0] offset;
   } rule_type;

   function automatic rule_type rule_rom(input logic [ZONE_W-1:0] zone);
      rule_type r;
      case (zone)
         3'd1: r = '{4'd3,  1'b1, 2'd0, 5'd1, 4'd10, 1'b1, 2'd0, 5'd2, 6'd60};
         3'd2: r = '{4'd3,  1'b1, 2'd0, 5'd2, 4'd10, 1'b1, 2'd0, 5'd3, 6'd60};
         3'd3: r = '{4'd3,  1'b1, 2'd0, 5'd3, 4'd10, 1'b1, 2'd0, 5'd4, 6'd60};
         3'd4: r = '{4'd3,  1'b0, 2'd2, 5'd2, 4'd11, 1'b0, 2'd1, 5'd2, 6'd60};
         3'd5: r = '{4'd9,  1'b0, 2'd1, 5'd0, 4'd4,  1'b0, 2'd1, 5'd0, 6'd60};
         3'd6: r = '{4'd10, 1'b0, 2'd1, 5'd2, 4'd4,  1'b0, 2'd1, 5'd3, 6'd60};
         3'd7: r = '{4'd9,  1'b1, 2'd0, 5'd2, 4'd4,  1'b0, 2'd1, 5'd3, 6'd60};
         default: r = '0;
      endcase
      return r;
   endfunction

   // days before the first of the month, common year
   function automatic logic [DOY_W-1:0] cum_days(input logic [3:0] month);
      logic [DOY_W-1:0] c;
      case (month)
         4'd1:  c = 9'd0;
         4'd2:  c = 9'd31;
         4'd3:  c = 9'd59;
         4'd4:  c = 9'd90;
         4'd5:  c = 9'd120;
         4'd6:  c = 9'd151;
         4'd7:  c = 9'd181;
         4'd8:  c = 9'd212;
         4'd9:  c = 9'd243;
         4'd10: c = 9'd273;
         4'd11: c = 9'd304;
         4'd12: c = 9'd334;
         default: c = 9'd0;
      endcase
      return c;
   endfunction

   function automatic logic [2:0] cum_mod7(input logic [3:0] month);
      logic [2:0] c;
      case (month)
         4'd2, 4'd3, 4'd11: c = 3'd3;
         4'd4, 4'd7:        c = 3'd6;
         4'd5:              c = 3'd1;
         4'd6:              c = 3'd4;
         4'd8:              c = 3'd2;
         4'd9, 4'd12:       c = 3'd5;
         default:           c = 3'd0;
      endcase
      return c;
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] l;
      case (month)
         4'd2:                     l = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:  l = 5'd30;
         default:                  l = 5'd31;
      endcase
      return l;
   endfunction

   // Day of year (Jan 1 = 0) of the nth or last Sunday of a month.
   function automatic logic [DOY_W-1:0] rule_doy(
      input logic [2:0] jan1_wd,
      input logic       leap,
      input logic [3:0] month,
      input logic       last,
      input logic [1:0] nth
   );
      logic       lp;
      logic [3:0] fw;
      logic [4:0] len;
      logic [2:0] lm7;
      logic [3:0] lw;
      logic [4:0] d;
      lp  = leap && (month > 4'd2);
      fw  = 4'(jan1_wd) + 4'(cum_mod7(month)) + 4'(lp);
      if (fw >= 4'd7) begin
         fw = fw - 4'd7;
      end
      len = month_len(month, leap);
      case (len)
         5'd28:   lm7 = 3'd6;
         5'd29:   lm7 = 3'd0;
         5'd30:   lm7 = 3'd1;
         default: lm7 = 3'd2;
      endcase
      lw = fw + 4'(lm7);
      if (lw >= 4'd7) begin
         lw = lw - 4'd7;
      end
      if (last) begin
         d = len - 5'(lw);
      end else begin
         d = 5'd1 + ((fw == 4'd0) ? 5'd0 : 5'd7 - 5'(fw)) + (5'(nth) - 5'd1) * 5'd7;
      end
      return cum_days(month) + 9'(lp) + 9'(d) - 9'd1;
   endfunction

endpackage

// ===== hw/rtl/dst_rule_evaluator.sv =====
// Channel | Dir | Ports                              | Beat contents
// --------+-----+------------------------------------+----------------------------------
// req     | in  | req_tvalid/req_tready/req_tdata    | year, month, day, hour, minute
// rsp     | out | rsp_tvalid/rsp_tready/rsp_tdata    | dst_active, offset_minutes
// csr     | in  | csr_valid/csr_ready/csr_data       | zone_select
//
// Six register stages, one query per cycle sustained while rsp_tready stays high;
// a query passes stages A, B, C, D, E and the output stage from req beat to rsp beat.
// Each stage holds while its successor is full and stalled, so empty stages still
// fill from req while a result waits on rsp; nothing is dropped or repeated.
// Synchronous active-high reset clears the stage valid bits and zone_select (off).
// csr_ready is always high; zone_select is sampled as a beat enters stage A.
module dst_rule_evaluator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [15:0] year, [23:16] month, [31:24] day, [39:32] hour, [47:40] minute
   input  logic [dre_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] dst_active, [6:1] offset_minutes, [7] zero
   output logic [dre_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dre_pkg::ZONE_W-1:0]        csr_data
);

   // ---------------- configuration ----------------
   logic [dre_pkg::ZONE_W-1:0] zone_ff, zone_in;

   assign csr_ready = 1'b1;
   assign zone_in   = csr_valid ? csr_data : zone_ff;

   // ---------------- request fields ----------------
   logic [15:0] f_year;
   logic [7:0]  f_month, f_day, f_hour, f_minute;

   assign f_year   = req_tdata[15:0];
   assign f_month  = req_tdata[23:16];
   assign f_day    = req_tdata[31:24];
   assign f_hour   = req_tdata[39:32];
   assign f_minute = req_tdata[47:40];

   // ---------------- stage handshake ----------------
   logic a_adv, b_adv, c_adv, d_adv, e_adv, o_adv;
   logic a_vld_ff, b_vld_ff, c_vld_ff, d_vld_ff, e_vld_ff, o_vld_ff;
   logic a_vld_in, b_vld_in, c_vld_in, d_vld_in, e_vld_in, o_vld_in;

   assign o_adv = !o_vld_ff || rsp_tready;
   assign e_adv = !e_vld_ff || o_adv;
   assign d_adv = !d_vld_ff || e_adv;
   assign c_adv = !c_vld_ff || d_adv;
   assign b_adv = !b_vld_ff || c_adv;
   assign a_adv = !a_vld_ff || b_adv;
   assign req_tready = a_adv;

   assign a_vld_in = a_adv ? req_tvalid : a_vld_ff;
   assign b_vld_in = b_adv ? a_vld_ff   : b_vld_ff;
   assign c_vld_in = c_adv ? b_vld_ff   : c_vld_ff;
   assign d_vld_in = d_adv ? c_vld_ff   : d_vld_ff;
   assign e_vld_in = e_adv ? d_vld_ff   : e_vld_ff;
   assign o_vld_in = o_adv ? e_vld_ff   : o_vld_ff;

   // ---------------- stage A: range check, year / 25 estimate ----------------
   // Year mod 400 is built as 16 * ((year >> 4) mod 25) + year[3:0].
   logic                              a_ok_ff, a_ok_in;
   logic [dre_pkg::ZONE_W-1:0]        a_zone_ff, a_zone_in;
   logic [11:0]                       a_yhi_ff, a_yhi_in;
   logic [3:0]                        a_ylo_ff, a_ylo_in;
   logic [7:0]                        a_q25_ff, a_q25_in;
   logic [dre_pkg::DOY_W-1:0]         a_ndoy_ff, a_ndoy_in;
   logic                              a_gtfeb_ff, a_gtfeb_in;
   logic [10:0]                       a_hm_ff, a_hm_in;
   logic [23:0]                       a_prod;

   always_comb begin
      a_ok_in    = (zone_ff != dre_pkg::ZONE_OFF) &&
                   (f_month >= 8'd1) && (f_month <= 8'd12) &&
                   (f_day >= 8'd1) && (f_day <= 8'd31) &&
                   (f_hour <= 8'd23) && (f_minute <= 8'd59);
      a_zone_in  = zone_ff;
      a_yhi_in   = f_year[15:4];
      a_ylo_in   = f_year[3:0];
      a_prod     = 24'(f_year[15:4]) * 24'(dre_pkg::RECIP25);
      a_q25_in   = a_prod[23:16];
      // day of year before the leap correction
      a_ndoy_in  = dre_pkg::cum_days(f_month[3:0]) + 9'(f_day[4:0]) - 9'd1;
      a_gtfeb_in = f_month > 8'd2;
      a_hm_in    = 11'(f_hour[4:0]) * 11'd60 + 11'(f_minute[5:0]);
   end

   // ---------------- stage B: year in 400-year cycle, Jan 1 weekday sum ----------------
   logic                              b_ok_ff;
   logic [dre_pkg::ZONE_W-1:0]        b_zone_ff;
   logic [8:0]                        b_v_ff, b_v_in;
   logic                              b_leap_ff, b_leap_in;
   logic [dre_pkg::DOY_W-1:0]         b_ndoy_ff;
   logic                              b_gtfeb_ff;
   logic [10:0]                       b_hm_ff;
   logic [11:0]                       b_diff;
   logic [8:0]                        b_k;
   logic [1:0]                        b_cent;

   always_comb begin
      b_diff = a_yhi_ff - 12'(a_q25_ff) * 12'd25;
      b_k    = {b_diff[4:0], a_ylo_ff};
      // centurial common years passed since the cycle start
      b_cent = 2'(b_k > 9'd100) + 2'(b_k > 9'd200) + 2'(b_k > 9'd300);
      // cycle year 0 opens on a Saturday; 365 = 1 mod 7
      b_v_in = 9'd6 + b_k + ((b_k + 9'd3) >> 2) - 9'(b_cent);
      b_leap_in = (b_k[1:0] == 2'd0) && (b_k != 9'd100) && (b_k != 9'd200) &&
                  (b_k != 9'd300);
   end

   // ---------------- stage C: Jan 1 weekday = v mod 7 ----------------
   logic                              c_ok_ff;
   logic [dre_pkg::ZONE_W-1:0]        c_zone_ff;
   logic [2:0]                        c_wd_ff, c_wd_in;
   logic                              c_leap_ff;
   logic [dre_pkg::DOY_W-1:0]         c_ndoy_ff;
   logic                              c_gtfeb_ff;
   logic [10:0]                       c_hm_ff;
   logic [19:0]                       c_prod;
   logic [8:0]                        c_rem;

   always_comb begin
      c_prod  = 20'(b_v_ff) * 20'(dre_pkg::RECIP7);
      c_rem   = b_v_ff - 9'(c_prod[19:13]) * 9'd7;
      c_wd_in = c_rem[2:0];
   end

   // ---------------- stage D: rule days and day-of-year values ----------------
   logic                              d_ok_ff;
   logic [dre_pkg::ZONE_W-1:0]        d_zone_ff;
   logic [dre_pkg::DOY_W-1:0]         d_sdoy_ff, d_sdoy_in;
   logic [dre_pkg::DOY_W-1:0]         d_edoy_ff, d_edoy_in;
   logic [dre_pkg::DOY_W-1:0]         d_ndoy_ff, d_ndoy_in;
   logic [10:0]                       d_hm_ff;
   dre_pkg::rule_type                 d_rule;

   always_comb begin
      d_rule    = dre_pkg::rule_rom(c_zone_ff);
      d_sdoy_in = dre_pkg::rule_doy(c_wd_ff, c_leap_ff, d_rule.s_month, d_rule.s_last,
                                    d_rule.s_nth);
      d_edoy_in = dre_pkg::rule_doy(c_wd_ff, c_leap_ff, d_rule.e_month, d_rule.e_last,
                                    d_rule.e_nth);
      d_ndoy_in = c_ndoy_ff + 9'(c_leap_ff && c_gtfeb_ff);
   end

   // ---------------- stage E: minute stamps from the start of the year ----------------
   logic                              e_ok_ff;
   logic [dre_pkg::ZONE_W-1:0]        e_zone_ff;
   logic [dre_pkg::STAMP_W-1:0]       e_start_ff, e_start_in;
   logic [dre_pkg::STAMP_W-1:0]       e_end_ff, e_end_in;
   logic [dre_pkg::STAMP_W-1:0]       e_now_ff, e_now_in;
   dre_pkg::rule_type                 e_rule;

   always_comb begin
      e_rule     = dre_pkg::rule_rom(d_zone_ff);
      e_start_in = 20'(d_sdoy_ff) * 20'(dre_pkg::MIN_PER_DAY) + 20'(e_rule.s_hour) * 20'd60;
      // end hour is daylight time; pull it back onto the standard scale
      e_end_in   = 20'(d_edoy_ff) * 20'(dre_pkg::MIN_PER_DAY) + 20'(e_rule.e_hour) * 20'd60
                   - 20'(e_rule.offset);
      e_now_in   = 20'(d_ndoy_ff) * 20'(dre_pkg::MIN_PER_DAY) + 20'(d_hm_ff);
   end

   // ---------------- output stage: window compare ----------------
   logic                              o_active_ff, o_active_in;
   logic [dre_pkg::OFFSET_W-1:0]      o_offset_ff, o_offset_in;
   logic                              o_after_start, o_before_end, o_hit;
   dre_pkg::rule_type                 o_rule;

   always_comb begin
      o_rule        = dre_pkg::rule_rom(e_zone_ff);
      o_after_start = e_now_ff >= e_start_ff;
      o_before_end  = e_now_ff < e_end_ff;
      // start after end: window wraps the year end (southern rules)
      if (e_start_ff < e_end_ff) begin
         o_hit = o_after_start && o_before_end;
      end else begin
         o_hit = o_after_start || o_before_end;
      end
      o_active_in = e_ok_ff && o_hit;
      o_offset_in = o_active_in ? o_rule.offset : '0;
   end

   assign rsp_tvalid = o_vld_ff;
   assign rsp_tdata  = {1'b0, o_offset_ff, o_active_ff};

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff  <= dre_pkg::ZONE_OFF;
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else begin
         zone_ff  <= zone_in;
         a_vld_ff <= a_vld_in;
         b_vld_ff <= b_vld_in;
         c_vld_ff <= c_vld_in;
         d_vld_ff <= d_vld_in;
         e_vld_ff <= e_vld_in;
         o_vld_ff <= o_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv) begin
         a_ok_ff    <= a_ok_in;
         a_zone_ff  <= a_zone_in;
         a_yhi_ff   <= a_yhi_in;
         a_ylo_ff   <= a_ylo_in;
         a_q25_ff   <= a_q25_in;
         a_ndoy_ff  <= a_ndoy_in;
         a_gtfeb_ff <= a_gtfeb_in;
         a_hm_ff    <= a_hm_in;
      end
      if (b_adv) begin
         b_ok_ff    <= a_ok_ff;
         b_zone_ff  <= a_zone_ff;
         b_v_ff     <= b_v_in;
         b_leap_ff  <= b_leap_in;
         b_ndoy_ff  <= a_ndoy_ff;
         b_gtfeb_ff <= a_gtfeb_ff;
         b_hm_ff    <= a_hm_ff;
      end
      if (c_adv) begin
         c_ok_ff    <= b_ok_ff;
         c_zone_ff  <= b_zone_ff;
         c_wd_ff    <= c_wd_in;
         c_leap_ff  <= b_leap_ff;
         c_ndoy_ff  <= b_ndoy_ff;
         c_gtfeb_ff <= b_gtfeb_ff;
         c_hm_ff    <= b_hm_ff;
      end
      if (d_adv) begin
         d_ok_ff    <= c_ok_ff;
         d_zone_ff  <= c_zone_ff;
         d_sdoy_ff  <= d_sdoy_in;
         d_edoy_ff  <= d_edoy_in;
         d_ndoy_ff  <= d_ndoy_in;
         d_hm_ff    <= c_hm_ff;
      end
      if (e_adv) begin
         e_ok_ff    <= d_ok_ff;
         e_zone_ff  <= d_zone_ff;
         e_start_ff <= e_start_in;
         e_end_ff   <= e_end_in;
         e_now_ff   <= e_now_in;
      end
      if (o_adv) begin
         o_active_ff <= o_active_in;
         o_offset_ff <= o_offset_in;
      end
   end

endmodule

// ===== hw/rtl/dre_checker.sv =====
`include "dst_rule_evaluator_assert.svh"

module dre_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [dre_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled result beat holds
   `DRE_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "rsp beat changed while stalled")

   // offset is 60 exactly when active, else 0; pad bit is zero
   `DRE_ASSERT(a_rsp_offset, rsp_tvalid |-> (rsp_tdata[7] == 1'b0) && ((rsp_tdata[0] && rsp_tdata[6:1] == 6'd60) || (!rsp_tdata[0] && rsp_tdata[6:1] == 6'd0)), "offset does not match active flag")

   // an empty output stage never blocks the request side
   `DRE_ASSERT(a_empty_ready, !rsp_tvalid |-> req_tready, "request stalled with empty output")

   // reset empties the pipeline
   `DRE_ASSERT_ALWAYS(a_reset_clear, reset |=> !rsp_tvalid, "result valid right after reset")

endmodule

bind dst_rule_evaluator dre_checker u_dre_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

   // Region codes as the CSR sees them; off comes from the package.
   localparam logic [dre_pkg::ZONE_W-1:0] ZONE_EU_WEST     = 3'd1;
   localparam logic [dre_pkg::ZONE_W-1:0] ZONE_EU_CENTRAL  = 3'd2;
   localparam logic [dre_pkg::ZONE_W-1:0] ZONE_EU_EAST     = 3'd3;
   localparam logic [dre_pkg::ZONE_W-1:0] ZONE_N_AMERICA   = 3'd4;
   localparam logic [dre_pkg::ZONE_W-1:0] ZONE_CHILE       = 3'd5;
   localparam logic [dre_pkg::ZONE_W-1:0] ZONE_AUSTRALIA   = 3'd6;
   localparam logic [dre_pkg::ZONE_W-1:0] ZONE_NEW_ZEALAND = 3'd7;

   localparam int RAND_PER_PHASE = 95;   // nine phases, ~850 queries in all
   localparam int DRAIN_CYCLES   = 12;   // six-stage pipe plus margin
   localparam int LONG_HOLD      = 300;  // rsp back-pressure stretch, cycles
   localparam int LAST_NTH       = -1;   // "last Sunday" in a rule entry

   // One query beat as the block sees it; year in the low bits.
   typedef struct packed {
      logic [7:0]  minute;
      logic [7:0]  hour;
      logic [7:0]  day;
      logic [7:0]  month;
      logic [15:0] year;
   } query_type;

   // One rsp beat, minus the pad bit.
   typedef struct packed {
      logic [dre_pkg::OFFSET_W-1:0] offset;
      logic                         active;
   } verdict_type;

   // Switchover rule; every transition falls on a Sunday.
   typedef struct packed {
      int s_month;
      int s_nth;
      int s_hour;    // standard time
      int e_month;
      int e_nth;
      int e_hour;    // daylight time
      int offset;
   } dst_rule_type;

   // rsp_tready stall patterns
   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_CHOKED, RX_PERIODIC} rx_mode_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [dre_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [dre_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [dre_pkg::ZONE_W-1:0]     csr_data = '0;

   query_type   query_backlog[$];     // queries not yet offered on req
   verdict_type pending_verdicts[$];  // predicted rsp beats, oldest first
   logic [dre_pkg::ZONE_W-1:0] zone_shadow = dre_pkg::ZONE_OFF;
   int          mismatch_cnt = 0;

   dst_rule_evaluator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // Calendar arithmetic, proleptic Gregorian, day 0 = 1970-01-01.
   // Integer division truncates toward zero, so eras before year 0 need
   // the -399 bias to floor.
   // ---------------------------------------------------------------------
   function automatic longint civil_days(longint yr, int mo, int dy);
      longint y, era, yoe, mp, doy, doe;
      y   = (mo <= 2) ? yr - 1 : yr;
      era = (y >= 0 ? y : y - 399) / 400;
      yoe = y - era * 400;
      mp  = (mo > 2) ? mo - 3 : mo + 9;
      doy = (153 * mp + 2) / 5 + dy - 1;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      return era * 146097 + doe - 719468;
   endfunction

   // 0 = Sunday
   function automatic int weekday(longint yr, int mo, int dy);
      longint w;
      w = (civil_days(yr, mo, dy) + 4) % 7;
      if (w < 0) begin
         w = w + 7;
      end
      return int'(w);
   endfunction

   function automatic int days_in_month(longint yr, int mo);
      bit leap;
      leap = (yr % 4 == 0 && yr % 100 != 0) || yr % 400 == 0;
      case (mo)
         2:             return leap ? 29 : 28;
         4, 6, 9, 11:   return 30;
         default:       return 31;
      endcase
   endfunction

   // Day of month of the nth (or last) Sunday; 0 when it does not exist.
   function automatic int sunday_of(longint yr, int mo, int nth);
      int last, fw, d;
      if (mo < 1 || mo > 12) begin
         return 0;
      end
      last = days_in_month(yr, mo);
      if (nth < 0) begin
         return last - weekday(yr, mo, last);
      end
      if (nth < 1) begin
         return 0;
      end
      fw = weekday(yr, mo, 1);
      d  = 1 + (7 - fw) % 7 + (nth - 1) * 7;
      return (d > last) ? 0 : d;
   endfunction

   function automatic dst_rule_type zone_rule(logic [dre_pkg::ZONE_W-1:0] zone);
      dst_rule_type r;
      case (zone)
         ZONE_EU_WEST:     r = '{3, LAST_NTH, 1, 10, LAST_NTH, 2, 60};
         ZONE_EU_CENTRAL:  r = '{3, LAST_NTH, 2, 10, LAST_NTH, 3, 60};
         ZONE_EU_EAST:     r = '{3, LAST_NTH, 3, 10, LAST_NTH, 4, 60};
         ZONE_N_AMERICA:   r = '{3, 2, 2, 11, 1, 2, 60};
         ZONE_CHILE:       r = '{9, 1, 0, 4, 1, 0, 60};
         ZONE_AUSTRALIA:   r = '{10, 1, 2, 4, 1, 3, 60};
         ZONE_NEW_ZEALAND: r = '{9, LAST_NTH, 2, 4, 1, 3, 60};
         default:          r = '{0, 0, 0, 0, 0, 0, 0};
      endcase
      return r;
   endfunction

   // Expected rsp beat for one query under one region setting.
   function automatic verdict_type dst_verdict(query_type q,
                                               logic [dre_pkg::ZONE_W-1:0] zone);
      verdict_type  v;
      dst_rule_type r;
      int           sd, ed;
      longint       now_m, start_m, end_m;
      bit           on;
      v = '0;
      if (zone == dre_pkg::ZONE_OFF) begin
         return v;
      end
      if (q.month < 1 || q.month > 12 || q.day < 1 || q.day > 31 ||
          q.hour > 23 || q.minute > 59) begin
         return v;
      end
      r  = zone_rule(zone);
      sd = sunday_of(q.year, r.s_month, r.s_nth);
      ed = sunday_of(q.year, r.e_month, r.e_nth);
      if (sd == 0 || ed == 0) begin
         return v;
      end
      // All three instants on the standard-time minute scale; the end hour
      // is given in daylight time, hence the offset comes off.
      now_m   = civil_days(q.year, q.month, q.day) * 1440 +
                int'(q.hour) * 60 + int'(q.minute);
      start_m = civil_days(q.year, r.s_month, sd) * 1440 + r.s_hour * 60;
      end_m   = civil_days(q.year, r.e_month, ed) * 1440 + r.e_hour * 60 - r.offset;
      // Southern rules wrap the year end.
      if (start_m < end_m) begin
         on = (now_m >= start_m) && (now_m < end_m);
      end else begin
         on = (now_m >= start_m) || (now_m < end_m);
      end
      if (on) begin
         v.active = 1'b1;
         v.offset = r.offset[dre_pkg::OFFSET_W-1:0];
      end
      return v;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus builders (called from the sequencer, off the rising edge)
   // ---------------------------------------------------------------------
   task automatic queue_query(int yr, int mo, int dy, int hr, int mi);
      query_type q;
      q.year   = 16'(yr);
      q.month  = 8'(mo);
      q.day    = 8'(dy);
      q.hour   = 8'(hr);
      q.minute = 8'(mi);
      query_backlog.push_back(q);
   endtask

   // Minute-of-day form; spills into the neighboring day as needed, which
   // may land on day 0 or 32 - fine, those are out-of-range cases anyway.
   task automatic queue_at(int yr, int mo, int dy, int mins);
      if (mins < 0) begin
         dy   = dy - 1;
         mins = mins + 1440;
      end else if (mins >= 1440) begin
         dy   = dy + 1;
         mins = mins - 1440;
      end
      queue_query(yr, mo, dy, mins / 60, mins % 60);
   endtask

   // Last minute before and first minute of both switchovers of a year.
   task automatic queue_switchover(logic [dre_pkg::ZONE_W-1:0] zone, int yr);
      dst_rule_type r;
      int sd, ed;
      r  = zone_rule(zone);
      sd = sunday_of(yr, r.s_month, r.s_nth);
      ed = sunday_of(yr, r.e_month, r.e_nth);
      queue_at(yr, r.s_month, sd, r.s_hour * 60 - 1);
      queue_at(yr, r.s_month, sd, r.s_hour * 60);
      queue_at(yr, r.e_month, ed, r.e_hour * 60 - r.offset - 1);
      queue_at(yr, r.e_month, ed, r.e_hour * 60 - r.offset);
   endtask

   // Half the queries cluster around a switchover (where the compare logic
   // actually toggles), a third are plain valid dates, the rest raw noise.
   task automatic queue_random(logic [dre_pkg::ZONE_W-1:0] zone);
      dst_rule_type r;
      int sel, yr, mo, dy, mins;
      r   = zone_rule(zone);
      sel = int'($urandom_range(0, 99));
      yr  = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 65535))
                                         : int'($urandom_range(1900, 2100));
      if (zone != dre_pkg::ZONE_OFF && sel < 50) begin
         if ($urandom_range(0, 1) == 1) begin
            mo   = r.s_month;
            dy   = sunday_of(yr, mo, r.s_nth);
            mins = r.s_hour * 60;
         end else begin
            mo   = r.e_month;
            dy   = sunday_of(yr, mo, r.e_nth);
            mins = r.e_hour * 60 - r.offset;
         end
         if (dy == 0) begin
            dy = 1;
         end
         dy   = dy + int'($urandom_range(0, 2)) - 1;
         mins = mins + int'($urandom_range(0, 180)) - 90;
         queue_at(yr, mo, dy, mins);
      end else if (sel < 85) begin
         queue_query(yr, int'($urandom_range(1, 12)), int'($urandom_range(1, 31)),
                     int'($urandom_range(0, 23)), int'($urandom_range(0, 59)));
      end else begin
         queue_query(int'($urandom_range(0, 65535)), int'($urandom_range(0, 255)),
                     int'($urandom_range(0, 255)), int'($urandom_range(0, 255)),
                     int'($urandom_range(0, 255)));
      end
   endtask

   // ---------------------------------------------------------------------
   // req driver: bursts of random length separated by random gaps; a beat
   // that is not taken stays put. Prediction happens on the accepting edge
   // against the zone in force at that moment.
   // ---------------------------------------------------------------------
   int        burst_left = 0;
   int        gap_left   = 0;
   query_type drv_q;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            pending_verdicts.push_back(dst_verdict(query_type'(req_tdata), zone_shadow));
         end
         if (req_tvalid && !req_tready) begin
            // beat held until taken
         end else if (gap_left != 0) begin
            gap_left   <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (query_backlog.size() != 0) begin
            drv_q      = query_backlog.pop_front();
            req_tdata  <= {drv_q.minute, drv_q.hour, drv_q.day, drv_q.month, drv_q.year};
            req_tvalid <= 1'b1;
            if (burst_left <= 1) begin
               // a third of the bursts run back to back with no gap at all
               if ($urandom_range(0, 2) == 0) begin
                  burst_left <= int'($urandom_range(20, 60));
                  gap_left   <= 0;
               end else begin
                  burst_left <= int'($urandom_range(1, 8));
                  gap_left   <= int'($urandom_range(1, 5));
               end
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // rsp receiver: cycles through stall patterns of random duration. Once
   // armed, it refuses rsp until its hold counter reaches LONG_HOLD, so the stage chain fills
   // and req_tready has to drop.
   // ---------------------------------------------------------------------
   rx_mode_type rx_mode   = RX_OPEN;
   int          mode_left = 0;
   logic [1:0]  rx_tick   = '0;
   bit          hold_armed = 1'b0;
   bit          hold_done  = 1'b0;
   int          hold_cnt   = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         mode_left  <= 0;
      end else if (hold_armed && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_cnt   <= hold_cnt + 1;
         if (hold_cnt == LONG_HOLD - 1) begin
            hold_done <= 1'b1;
         end
      end else begin
         rx_tick <= rx_tick + 2'd1;
         if (mode_left == 0) begin
            rx_mode   <= rx_mode_type'($urandom_range(0, 3));
            mode_left <= int'($urandom_range(20, 120));
         end else begin
            mode_left <= mode_left - 1;
         end
         case (rx_mode)
            RX_OPEN:     rsp_tready <= 1'b1;
            RX_COIN:     rsp_tready <= ($urandom_range(0, 1) == 1);
            RX_CHOKED:   rsp_tready <= ($urandom_range(0, 3) == 0);
            default:     rsp_tready <= (rx_tick != 2'd3);
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // rsp monitor: every accepted beat against the oldest prediction.
   // ---------------------------------------------------------------------
   verdict_type mon_exp;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_verdicts.size() == 0) begin
            $error("rsp beat 0x%02h with no query outstanding", rsp_tdata);
            mismatch_cnt = mismatch_cnt + 1;
         end else begin
            mon_exp = pending_verdicts.pop_front();
            if (rsp_tdata[0] !== mon_exp.active) begin
               $error("dst_active: expected %0d, actual %0d", mon_exp.active, rsp_tdata[0]);
               mismatch_cnt = mismatch_cnt + 1;
            end
            if (rsp_tdata[dre_pkg::OFFSET_W:1] !== mon_exp.offset) begin
               $error("offset_minutes: expected %0d, actual %0d",
                      mon_exp.offset, rsp_tdata[dre_pkg::OFFSET_W:1]);
               mismatch_cnt = mismatch_cnt + 1;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------

   // Block is quiet: nothing queued, nothing on req, nothing in flight.
   task automatic wait_idle();
      @(negedge clock);
      while (query_backlog.size() != 0 || req_tvalid || pending_verdicts.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_zone(logic [dre_pkg::ZONE_W-1:0] zone);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= zone;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      zone_shadow = zone;
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_random(logic [dre_pkg::ZONE_W-1:0] zone);
      repeat (RAND_PER_PHASE) queue_random(zone);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Out of reset the region is off: everything reads inactive.
      queue_query(2024, 7, 1, 12, 0);
      queue_query(2024, 1, 1, 0, 0);
      run_random(dre_pkg::ZONE_OFF);
      wait_idle();

      // North America: both switchovers, then field extremes and range
      // violations.
      write_zone(ZONE_N_AMERICA);
      queue_switchover(ZONE_N_AMERICA, 2024);
      queue_query(0, 7, 4, 12, 0);
      queue_query(65535, 7, 4, 12, 0);
      queue_query(2024, 0, 10, 12, 0);
      queue_query(2024, 13, 10, 12, 0);
      queue_query(2024, 255, 10, 12, 0);
      queue_query(2024, 7, 0, 12, 0);
      queue_query(2024, 7, 32, 12, 0);
      queue_query(2024, 7, 255, 12, 0);
      queue_query(2024, 7, 4, 24, 0);
      queue_query(2024, 7, 4, 255, 0);
      queue_query(2024, 7, 4, 12, 60);
      queue_query(2024, 7, 4, 12, 255);
      queue_query(2024, 2, 30, 12, 0);      // past month end, rolls into March
      queue_query(2024, 12, 31, 23, 59);
      // Long rsp stall while this phase's random queries keep coming.
      hold_armed = 1'b1;
      run_random(ZONE_N_AMERICA);
      wait_idle();

      // Australia: start in October, end in April, so the window wraps.
      write_zone(ZONE_AUSTRALIA);
      queue_switchover(ZONE_AUSTRALIA, 2024);
      run_random(ZONE_AUSTRALIA);
      wait_idle();

      write_zone(ZONE_NEW_ZEALAND);
      run_random(ZONE_NEW_ZEALAND);
      wait_idle();

      write_zone(ZONE_EU_WEST);
      run_random(ZONE_EU_WEST);
      wait_idle();

      write_zone(ZONE_EU_CENTRAL);
      run_random(ZONE_EU_CENTRAL);
      wait_idle();

      write_zone(ZONE_EU_EAST);
      run_random(ZONE_EU_EAST);
      wait_idle();

      write_zone(ZONE_CHILE);
      run_random(ZONE_CHILE);
      wait_idle();

      // Explicit write back to off.
      write_zone(dre_pkg::ZONE_OFF);
      run_random(dre_pkg::ZONE_OFF);
      wait_idle();

      if (mismatch_cnt == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run (~850 beats under heavy
   // stall plus the long hold).
   initial begin
      #2000000;
      $display("tb: FAIL");
      $finish;
   end

endmodule
